FILE: rtl/sol_pkg.sv
// shared types and constants for the sorted offset lower-bound search block
// no dependencies; used by every other file of the block except sol_ram
`default_nettype none

package sol_pkg;

    // field widths
    localparam int VALUE_W  = 64;
    localparam int TARGET_W = VALUE_W + 1;
    localparam int OFFSET_W = 32;
    localparam int POS_W    = 11;
    localparam int OP_W     = 2;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    // operation codes
    localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    // classified command: append value or query target, sign extended
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [TARGET_W-1:0] data;
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/sol_item_if.sv
// request channel carrying one operation and value per request
// depends on sol_pkg for field widths
`default_nettype none

interface sol_item_if;
    logic                        valid;
    logic                        ready;
    logic [sol_pkg::OP_W-1:0]    operation;
    logic [sol_pkg::VALUE_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

`default_nettype wire

FILE: rtl/sol_result_if.sv
// result channel carrying the insertion index and the sticky drop flag
// depends on sol_pkg for field widths
`default_nettype none

interface sol_result_if;
    logic                      valid;
    logic                      ready;
    logic [sol_pkg::POS_W-1:0] position;
    logic                      load_dropped;

    modport source (output valid, output position, output load_dropped, input ready);
    modport sink   (input valid, input position, input load_dropped, output ready);
endinterface

`default_nettype wire

FILE: rtl/sorted_offset_lower_bound_top.sv
// top level of the sorted offset lower-bound search block
// depends on sol_pkg, sol_item_if, sol_result_if, sol_front and sol_back
`default_nettype none

// Requests arrive on i_item: operation 0 appends value to the sorted store,
// 1 queries with value, 2 restarts (empties the store, rewinds the pointer),
// 3 is accepted and ignored. Each query yields one result on o_result: the
// forward-only search pointer after it has moved past every stored entry
// below value + target_offset, plus the sticky load-dropped flag.
// target_offset is written through the APB port, every address decoding to
// it; the user must write it only while idle, the block does not enforce it.
// Requests pass through a four-entry command queue into the execution unit.
// An append or restart executes as soon as it is popped; a query first
// enters a scan that moves the pointer entry by entry, paced by the store
// memory's registered read feeding the compare, and then emits its result.
// Pointer moves add up to at most the entry count; no command pops mid-scan.
// When o_result stalls, one result waits in the output register and the
// queue keeps taking requests until it fills. Synchronous reset clears the
// store count, pointer, drop flag, queue and offset; no clearing pass runs.
module sorted_offset_lower_bound_top #(
    parameter int HAYSTACK_DEPTH = 1024
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    sol_item_if.sink                     i_item,
    sol_result_if.source                 o_result,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [1:0]                   paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [sol_pkg::OFFSET_W-1:0] r_offset;
    logic                         w_cmd_valid;
    sol_pkg::t_cmd                w_cmd;
    logic                         w_cmd_pop;

    // configuration register, the only one, decoded from every address
    assign pready = 1'b1;
    assign prdata = r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (psel && penable && pwrite && pready && paddr[1:0] <= 2'd3) begin
            r_offset <= pwdata;
        end
    end

    // request intake and command queue
    sol_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_offset    (r_offset),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    // execution unit with the haystack store
    sol_back #(
        .HAYSTACK_DEPTH (HAYSTACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

FILE: rtl/sol_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module sol_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/sol_front.sv
// front end: accepts requests, forms query targets, queues commands in order
// depends on sol_pkg and sol_item_if
`default_nettype none

module sol_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    sol_item_if.sink                     i_item,
    input  wire  [sol_pkg::OFFSET_W-1:0] i_offset,
    output logic                         o_cmd_valid,
    output sol_pkg::t_cmd                o_cmd,
    input  wire                          i_cmd_pop
);

    sol_pkg::t_cmd                  r_queue [sol_pkg::QUEUE_DEPTH];
    logic [sol_pkg::QADDR_W-1:0]    r_head;
    logic [sol_pkg::QADDR_W-1:0]    r_tail;
    logic [sol_pkg::QFILL_W-1:0]    r_fill;
    logic [sol_pkg::TARGET_W-1:0]   w_value_ext;
    logic [sol_pkg::TARGET_W-1:0]   w_offset_ext;
    sol_pkg::t_cmd                  w_cmd;
    logic                           w_accept;
    logic                           w_push;
    logic                           w_pop;

    // target is value plus offset in 65 bits, so it never wraps
    assign w_value_ext  = {i_item.value[sol_pkg::VALUE_W-1], i_item.value};
    assign w_offset_ext = {{(sol_pkg::TARGET_W - sol_pkg::OFFSET_W){i_offset[sol_pkg::OFFSET_W-1]}},
                           i_offset};

    always_comb begin
        w_cmd.op   = i_item.operation;
        w_cmd.data = (i_item.operation == sol_pkg::OP_QUERY) ? (w_value_ext + w_offset_ext)
                                                             : w_value_ext;
    end

    // unused operation code is accepted and discarded
    assign i_item.ready = (r_fill != sol_pkg::QFILL_W'(sol_pkg::QUEUE_DEPTH));
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_push       = w_accept && (i_item.operation == sol_pkg::OP_APPEND ||
                                       i_item.operation == sol_pkg::OP_QUERY  ||
                                       i_item.operation == sol_pkg::OP_RESTART);
    assign w_pop        = i_cmd_pop && o_cmd_valid;

    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd       = r_queue[r_head];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_tail] <= w_cmd;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            if (w_push) begin
                r_tail <= r_tail + 1'b1;
            end
            if (w_pop) begin
                r_head <= r_head + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sol_back.sv
// back end: executes appends, restarts and pointer scans against the store
// depends on sol_pkg, sol_result_if and sol_ram
`default_nettype none

module sol_back #(
    parameter int HAYSTACK_DEPTH = 1024
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_cmd_valid,
    input  sol_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    sol_result_if.source  o_result
);

    localparam int ADDR_W = $clog2(HAYSTACK_DEPTH);
    localparam int PTR_W  = $clog2(HAYSTACK_DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                          r_state;
    logic                          n_state;
    logic [PTR_W-1:0]              r_ptr;
    logic [PTR_W-1:0]              n_ptr;
    logic [PTR_W-1:0]              r_count;
    logic [PTR_W-1:0]              n_count;
    logic                          r_dropped;
    logic                          n_dropped;
    logic [sol_pkg::TARGET_W-1:0]  r_target;
    logic                          r_out_valid;
    logic [sol_pkg::POS_W-1:0]     r_out_pos;
    logic                          r_out_drop;
    logic                          w_we;
    logic                          w_advance;
    logic                          w_emit;
    logic                          w_ptr_ok;
    logic                          w_below;
    logic [ADDR_W-1:0]             w_raddr;
    logic [sol_pkg::VALUE_W-1:0]   w_rdata;

    // haystack store
    sol_ram #(
        .WIDTH (sol_pkg::VALUE_W),
        .DEPTH (HAYSTACK_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_cmd.data[sol_pkg::VALUE_W-1:0]),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // entry under the pointer compared with the 65-bit target
    assign w_ptr_ok = (r_ptr < r_count);
    assign w_below  = ($signed({w_rdata[sol_pkg::VALUE_W-1], w_rdata}) < $signed(r_target));

    // read the next entry while advancing, else keep the current one
    assign w_raddr = w_advance ? n_ptr[ADDR_W-1:0] : r_ptr[ADDR_W-1:0];

    // command execution
    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_count   = r_count;
        n_dropped = r_dropped;
        o_cmd_pop = 1'b0;
        w_we      = 1'b0;
        w_advance = 1'b0;
        w_emit    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.op)
                        sol_pkg::OP_APPEND: begin
                            if (r_count < PTR_W'(HAYSTACK_DEPTH)) begin
                                w_we    = 1'b1;
                                n_count = r_count + 1'b1;
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        sol_pkg::OP_QUERY: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_count = '0;
                            n_ptr   = '0;
                        end
                    endcase
                end
            end
            default: begin
                if (w_ptr_ok && w_below) begin
                    w_advance = 1'b1;
                    n_ptr     = r_ptr + 1'b1;
                end else if (!r_out_valid || o_result.ready) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ptr     <= '0;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    // query target
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.op == sol_pkg::OP_QUERY) begin
            r_target <= i_cmd.data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_pos  <= sol_pkg::POS_W'(r_ptr);
            r_out_drop <= r_dropped;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.position     = r_out_pos;
    assign o_result.load_dropped = r_out_drop;

    // pointer stays within the filled part of the store
    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= r_count)
        else $error("search pointer beyond entry count");

    // entry count never exceeds the store depth
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= PTR_W'(HAYSTACK_DEPTH))
        else $error("entry count beyond store depth");

    // restart empties the store and rewinds the pointer
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_cmd_valid && i_cmd.op == sol_pkg::OP_RESTART)
        |=> (r_count == '0 && r_ptr == '0))
        else $error("restart did not clear count and pointer");

    // drop flag is sticky
    a_drop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropped |=> r_dropped)
        else $error("drop flag cleared without reset");

    // a result is only produced from a scan
    a_emit_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> ($past(r_state) == S_SCAN))
        else $error("result produced outside a scan");

endmodule

`default_nettype wire

FILE: verif/tb_sorted_offset_lower_bound_top.sv
// testbench for sorted_offset_lower_bound_top: directed and random requests,
// each query result checked against an in-bench model of store and pointer
// depends on sol_pkg, sol_item_if, sol_result_if and the block's rtl
`default_nettype none

module tb_sorted_offset_lower_bound_top;

    localparam int HAY_DEPTH     = 1024;
    localparam int RANDOM_REQS   = 140;
    localparam int SETTLE_CYCLES = 40;

    localparam logic [sol_pkg::OP_W-1:0] OP_UNUSED   = 2'd3;
    localparam logic [1:0]               ADDR_OFFSET = 2'd0;

    localparam longint VAL_MIN = 64'sh8000_0000_0000_0000;
    localparam longint VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [sol_pkg::OP_W-1:0]    op;
        logic [sol_pkg::VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [sol_pkg::POS_W-1:0] position;
        logic                      load_dropped;
    } t_answer;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [1:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    sol_item_if   item_ch ();
    sol_result_if result_ch ();

    sorted_offset_lower_bound_top #(
        .HAYSTACK_DEPTH(HAY_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_result(result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // model of the block's store, pointer, flag and offset
    logic [sol_pkg::VALUE_W-1:0]         hay_model [HAY_DEPTH];
    int unsigned                         hay_fill;
    int unsigned                         scan_pos;
    logic                                drop_seen;
    logic signed [sol_pkg::OFFSET_W-1:0] offset_model;

    t_req    req_backlog[$];
    t_answer answer_queue[$];
    t_answer oldest_answer;

    int send_idle_pct;
    int recv_stall_pct;
    int fail_count;
    int random_reqs;
    int planned_fill;

    initial begin
        item_ch.valid     = 1'b0;
        item_ch.operation = sol_pkg::OP_APPEND;
        item_ch.value     = '0;
        result_ch.ready   = 1'b0;
        hay_fill          = 0;
        scan_pos          = 0;
        drop_seen         = 1'b0;
        offset_model      = '0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        fail_count        = 0;
        random_reqs       = 0;
        planned_fill      = 0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    // advance the model by one accepted request
    function automatic void apply_request(input t_req r);
        logic signed [sol_pkg::TARGET_W-1:0] target;
        logic signed [sol_pkg::TARGET_W-1:0] entry;
        t_answer                             a;
        case (r.op)
            sol_pkg::OP_APPEND: begin
                if (hay_fill < HAY_DEPTH) begin
                    hay_model[hay_fill] = r.value;
                    hay_fill++;
                end else begin
                    drop_seen = 1'b1;
                end
            end
            sol_pkg::OP_RESTART: begin
                hay_fill = 0;
                scan_pos = 0;
            end
            sol_pkg::OP_QUERY: begin
                // one bit wider so the target never wraps
                target = $signed({r.value[sol_pkg::VALUE_W-1], r.value})
                       + $signed({{(sol_pkg::TARGET_W-sol_pkg::OFFSET_W)
                                   {offset_model[sol_pkg::OFFSET_W-1]}},
                                  offset_model});
                while (scan_pos < hay_fill) begin
                    entry = $signed({hay_model[scan_pos][sol_pkg::VALUE_W-1],
                                     hay_model[scan_pos]});
                    if (entry >= target) break;
                    scan_pos++;
                end
                a.position     = sol_pkg::POS_W'(scan_pos);
                a.load_dropped = drop_seen;
                answer_queue.push_back(a);
            end
            default: ;
        endcase
    endfunction

    // request driver: head of the backlog is what is offered while valid is high
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                apply_request(req_backlog.pop_front());
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (req_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    item_ch.valid     <= 1'b1;
                    item_ch.operation <= req_backlog[0].op;
                    item_ch.value     <= req_backlog[0].value;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (answer_queue.size() == 0) begin
                report_mismatch($sformatf("result with no query waiting, position %0d",
                                          result_ch.position));
            end else begin
                oldest_answer = answer_queue.pop_front();
                if (result_ch.position !== oldest_answer.position)
                    report_mismatch($sformatf("position %0d, model %0d",
                                              result_ch.position, oldest_answer.position));
                if (result_ch.load_dropped !== oldest_answer.load_dropped)
                    report_mismatch($sformatf("load_dropped %b, model %b",
                                              result_ch.load_dropped,
                                              oldest_answer.load_dropped));
            end
        end
        result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic void queue_req(input logic [sol_pkg::OP_W-1:0] op, input longint v);
        t_req r;
        r.op    = op;
        r.value = v;
        req_backlog.push_back(r);
        if (op != OP_UNUSED) random_reqs++;
        if (op == sol_pkg::OP_APPEND) planned_fill++;
        if (op == sol_pkg::OP_RESTART) planned_fill = 0;
    endfunction

    function automatic void insert_sorted(ref longint q[$], input longint v);
        int     j;
        longint tmp;
        q.push_back(v);
        j = q.size() - 1;
        while (j > 0 && q[j-1] > q[j]) begin
            tmp    = q[j];
            q[j]   = q[j-1];
            q[j-1] = tmp;
            j--;
        end
    endfunction

    // mostly full-range values, some near the extremes or near zero
    function automatic longint rand_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return VAL_MIN + longint'($urandom_range(0, 3));
                    1: return VAL_MAX - longint'($urandom_range(0, 3));
                    2: return 0;
                    default: return -1;
                endcase
            end
            1, 2: return longint'($urandom_range(0, 2000)) - 1000;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // all requests accepted, all results in, then a pause for appends in flight
    task automatic wait_settled();
        while (req_backlog.size() > 0 || answer_queue.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb write of the offset, then read back
    task automatic write_offset(input logic [31:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_OFFSET;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        offset_model = v;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== v)
            report_mismatch($sformatf("offset read back %h, written %h", prdata, v));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // sorted loads then ascending queries, many landing on stored values
    task automatic plan_search_run(input bit fresh);
        longint hay[$];
        longint needles[$];
        int     n_loads;
        int     n_queries;
        longint h;
        if (fresh || planned_fill + 64 > HAY_DEPTH) queue_req(sol_pkg::OP_RESTART, rand_value());
        n_loads = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 10);
        repeat (n_loads) insert_sorted(hay, rand_value());
        foreach (hay[i]) queue_req(sol_pkg::OP_APPEND, hay[i]);
        n_queries = $urandom_range(1, 20);
        repeat (n_queries) begin
            if (hay.size() > 0 && $urandom_range(0, 1) == 1) begin
                h = hay[$urandom_range(0, hay.size() - 1)];
                insert_sorted(needles, h - longint'(offset_model)
                                       + longint'($urandom_range(0, 2)) - 1);
            end else begin
                insert_sorted(needles, rand_value());
            end
        end
        foreach (needles[i]) queue_req(sol_pkg::OP_QUERY, needles[i]);
    endtask

    // unordered mix of every code, with unsorted loads and unordered queries
    task automatic plan_noise_run();
        logic [sol_pkg::OP_W-1:0] op;
        repeat ($urandom_range(4, 16)) begin
            op = sol_pkg::OP_W'($urandom_range(0, 3));
            if (op == sol_pkg::OP_APPEND && planned_fill + 64 > HAY_DEPTH)
                op = sol_pkg::OP_RESTART;
            queue_req(op, rand_value());
        end
    endtask

    // fill the store to the top, overflow it, then sweep queries across it
    task automatic plan_full_store();
        longint hay[$];
        queue_req(sol_pkg::OP_RESTART, rand_value());
        repeat (HAY_DEPTH) insert_sorted(hay, rand_value());
        foreach (hay[i]) queue_req(sol_pkg::OP_APPEND, hay[i]);
        repeat (3) queue_req(sol_pkg::OP_APPEND, rand_value());
        for (int i = 0; i < 8; i++)
            queue_req(sol_pkg::OP_QUERY,
                      hay[i*128 + $urandom_range(0, 127)] - longint'(offset_model));
        queue_req(sol_pkg::OP_QUERY, VAL_MAX);
        queue_req(sol_pkg::OP_QUERY, VAL_MAX);
    endtask

    // stimulus
    initial begin
        int seq;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset offset: empty store, unused code, extremes of the value
        queue_req(sol_pkg::OP_QUERY, 0);
        queue_req(OP_UNUSED, -1);
        queue_req(sol_pkg::OP_APPEND, VAL_MIN);
        queue_req(sol_pkg::OP_APPEND, -1);
        queue_req(sol_pkg::OP_APPEND, 0);
        queue_req(sol_pkg::OP_APPEND, VAL_MAX);
        queue_req(sol_pkg::OP_QUERY, VAL_MIN);
        queue_req(sol_pkg::OP_QUERY, 0);
        queue_req(sol_pkg::OP_QUERY, VAL_MAX);
        queue_req(sol_pkg::OP_RESTART, 0);
        queue_req(sol_pkg::OP_QUERY, VAL_MAX);
        wait_settled();

        // target above every 64-bit value
        write_offset(32'h7FFF_FFFF);
        queue_req(sol_pkg::OP_APPEND, VAL_MAX);
        queue_req(sol_pkg::OP_QUERY, VAL_MAX);
        queue_req(sol_pkg::OP_RESTART, -1);
        wait_settled();

        // offset at its minimum: the lowest query's target is below every 64-bit value
        write_offset(32'h8000_0000);
        queue_req(sol_pkg::OP_APPEND, VAL_MIN);
        queue_req(sol_pkg::OP_APPEND, 0);
        queue_req(sol_pkg::OP_QUERY, VAL_MIN);
        queue_req(sol_pkg::OP_QUERY, 0);
        queue_req(sol_pkg::OP_RESTART, VAL_MIN);
        wait_settled();

        // random runs; the sender holds off before each offset change until all is in
        random_reqs = 0;
        seq         = 0;
        while (random_reqs < RANDOM_REQS) begin
            wait_settled();
            case (seq % 6)
                0: write_offset(32'h0);
                1: write_offset(32'h7FFF_FFFF);
                2: write_offset(32'h8000_0000);
                4: write_offset(32'($urandom_range(0, 200)) - 32'd100);
                default: write_offset($urandom);
            endcase
            case (seq % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            if ($urandom_range(0, 9) < 7) plan_search_run($urandom_range(0, 3) != 0);
            else plan_noise_run();
            while (req_backlog.size() > 2) @(posedge i_clk);
            seq++;
        end
        wait_settled();

        // full store last: the drop flag stays set from here on
        send_idle_pct  = 7;
        recv_stall_pct = 7;
        write_offset(32'h7FFF_FFFF);
        plan_full_store();
        wait_settled();
        write_offset($urandom);
        plan_search_run(1'b1);
        plan_noise_run();
        plan_search_run(1'b1);
        wait_settled();

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/sol_pkg.sv
rtl/sol_item_if.sv
rtl/sol_result_if.sv
rtl/sol_ram.sv
rtl/sol_front.sv
rtl/sol_back.sv
rtl/sorted_offset_lower_bound_top.sv
verif/tb_sorted_offset_lower_bound_top.sv
